>>> rtl/ppe_pkg.sv
// Package with the widths shared by the perfect power exponent modules.
package ppe_pkg;

  localparam int VALUE_BITS = 32;
  localparam int EXP_W      = 5;
  localparam int CNT_W      = $clog2(VALUE_BITS);
  localparam int STEP_W     = $clog2(VALUE_BITS);

  typedef logic [VALUE_BITS-1:0] word_t;
  typedef logic [CNT_W-1:0]      cnt_t;

endpackage

>>> rtl/perfect_power_exponent_top.sv
// Top level: trial-division sequencer computing the perfect power exponent.
// Every division is done by the shared divider.
// An item needs one division per trial divisor up to sqrt(|value|) plus one per prime factor,
// so up to roughly 23200 divisions for a large prime magnitude.
// One item is worked on at a time; the next is taken once the result is registered.
// Reset is asynchronous and active low and returns the block to idle with no result.
module perfect_power_exponent_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  ppe_pkg::word_t             value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ppe_pkg::EXP_W-1:0]  exponent_o
);
  import ppe_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_START = 7'b0000010,
    ST_WAIT  = 7'b0000100,
    ST_GCD   = 7'b0001000,
    ST_FIX   = 7'b0010000,
    ST_STRIP = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic             neg_q, neg_d;
  logic             inner_q, inner_d;
  word_t            n_q, n_d;
  word_t            d_q, d_d;
  cnt_t             g_q, g_d;
  cnt_t             c_q, c_d;
  logic             out_valid_q, out_valid_d;
  logic [EXP_W-1:0] exponent_q, exponent_d;

  logic  div_start;
  logic  div_done;
  word_t div_quot;
  word_t div_rem;
  word_t mag;
  word_t d_next;

  ppe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (n_q),
    .divisor_i  (d_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign mag       = value_i[VALUE_BITS-1] ? (~value_i + VALUE_BITS'(1)) : value_i;
  assign d_next    = (d_q == VALUE_BITS'(2)) ? VALUE_BITS'(3) : (d_q + VALUE_BITS'(2));
  assign div_start = (state_q == ST_START);

  always_comb begin
    state_d     = state_q;
    neg_d       = neg_q;
    inner_d     = inner_q;
    n_d         = n_q;
    d_d         = d_q;
    g_d         = g_q;
    c_d         = c_q;
    out_valid_d = out_valid_q;
    exponent_d  = exponent_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          neg_d   = value_i[VALUE_BITS-1];
          n_d     = mag;
          d_d     = VALUE_BITS'(2);
          g_d     = '0;
          c_d     = '0;
          inner_d = 1'b0;
          if (mag < VALUE_BITS'(2)) begin
            state_d = ST_FIX;
          end else begin
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          if (inner_q) begin
            if (div_rem == '0) begin
              n_d     = div_quot;
              c_d     = c_q + CNT_W'(1);
              state_d = ST_START;
            end else begin
              state_d = ST_GCD;
            end
          end else if (div_quot < d_q) begin
            state_d = ST_FIX;
          end else if (div_rem == '0) begin
            n_d     = div_quot;
            c_d     = CNT_W'(1);
            inner_d = 1'b1;
            state_d = ST_START;
          end else begin
            d_d     = d_next;
            state_d = ST_START;
          end
        end
      end
      ST_GCD: begin
        if (g_q == '0 || g_q == c_q) begin
          g_d     = c_q;
          d_d     = d_next;
          inner_d = 1'b0;
          state_d = ST_START;
        end else if (g_q > c_q) begin
          g_d = g_q - c_q;
        end else begin
          c_d = c_q - g_q;
        end
      end
      ST_FIX: begin
        if (n_q != VALUE_BITS'(1) || g_q == '0) begin
          g_d = CNT_W'(1);
        end
        state_d = ST_STRIP;
      end
      ST_STRIP: begin
        if (neg_q && !g_q[0]) begin
          g_d = g_q >> 1;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          exponent_d  = EXP_W'(g_q);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q      <= neg_d;
    inner_q    <= inner_d;
    n_q        <= n_d;
    d_q        <= d_d;
    g_q        <= g_d;
    c_q        <= c_d;
    exponent_q <= exponent_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign exponent_o  = exponent_q;

endmodule

>>> rtl/ppe_div.sv
// Restoring divider producing one quotient bit per cycle.
module ppe_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  ppe_pkg::word_t  dividend_i,
  input  ppe_pkg::word_t  divisor_i,
  output logic            done_o,
  output ppe_pkg::word_t  quot_o,
  output ppe_pkg::word_t  rem_o
);
  import ppe_pkg::*;

  logic                busy_q;
  logic                done_q;
  logic [STEP_W-1:0]   step_q;
  word_t               quot_q;
  word_t               rem_q;
  word_t               divisor_q;
  logic [VALUE_BITS:0] rem_sh;
  logic [VALUE_BITS:0] diff;

  assign rem_sh = {rem_q, quot_q[VALUE_BITS-1]};
  assign diff   = rem_sh - {1'b0, divisor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= STEP_W'(VALUE_BITS - 1);
    end else if (busy_q) begin
      if (step_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        step_q <= step_q - STEP_W'(1);
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q    <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      if (diff[VALUE_BITS]) begin
        rem_q <= rem_sh[VALUE_BITS-1:0];
      end else begin
        rem_q <= diff[VALUE_BITS-1:0];
      end
      quot_q <= {quot_q[VALUE_BITS-2:0], ~diff[VALUE_BITS]};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule
